@@ design/rvd_pkg.sv @@
// ----------------------------------------------------------------------------
// RV64I decoder package
// Codes, opcodes, fixed instruction words and the decoded record type
// used by the decoder module.
// ----------------------------------------------------------------------------
package rvd_pkg;

  typedef enum logic [3:0] {
    CLS_UNKNOWN  = 4'd0,
    CLS_NOP      = 4'd1,
    CLS_CSR_NONE = 4'd2,
    CLS_CSR_USE  = 4'd3,
    CLS_ECALL    = 4'd4,
    CLS_MRET     = 4'd5,
    CLS_FENCE    = 4'd6,
    CLS_LOAD     = 4'd7,
    CLS_STORE    = 4'd8,
    CLS_UPPER    = 4'd9,
    CLS_JUMP     = 4'd10,
    CLS_BRANCH   = 4'd11,
    CLS_ALU      = 4'd12
  } op_class_t;

  typedef enum logic [3:0] {
    ALU_NONE = 4'd0,
    ALU_ADD  = 4'd1,
    ALU_SUB  = 4'd2,
    ALU_XOR  = 4'd3,
    ALU_OR   = 4'd4,
    ALU_AND  = 4'd5,
    ALU_SLL  = 4'd6,
    ALU_SRL  = 4'd7,
    ALU_SRA  = 4'd8,
    ALU_SLT  = 4'd9
  } alu_op_t;

  typedef enum logic [2:0] {
    IMM_NONE,
    IMM_I,
    IMM_S,
    IMM_B,
    IMM_U,
    IMM_J
  } imm_fmt_t;

  localparam logic [6:0] OPC_SYSTEM  = 7'b1110011;
  localparam logic [6:0] OPC_LOAD    = 7'b0000011;
  localparam logic [6:0] OPC_STORE   = 7'b0100011;
  localparam logic [6:0] OPC_LUI     = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC   = 7'b0010111;
  localparam logic [6:0] OPC_JAL     = 7'b1101111;
  localparam logic [6:0] OPC_JALR    = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH  = 7'b1100011;
  localparam logic [6:0] OPC_OP      = 7'b0110011;
  localparam logic [6:0] OPC_OPIMM   = 7'b0010011;
  localparam logic [6:0] OPC_OP32    = 7'b0111011;
  localparam logic [6:0] OPC_OPIMM32 = 7'b0011011;

  localparam logic [31:0] W_NOP       = 32'd19;
  localparam logic [31:0] W_ECALL     = 32'd115;
  localparam logic [31:0] W_MRET      = 32'd807403635;
  localparam logic [31:0] W_FENCE     = 32'd267386895;
  localparam logic [31:0] W_CSR_SRC_A = 32'd873631859;
  localparam logic [31:0] W_CSR_SRC_B = 32'd810717299;
  localparam logic [31:0] W_CSR_DST   = 32'd874524531;

  localparam logic [4:0] REG_CSR_SRC = 5'd5;
  localparam logic [4:0] REG_CSR_DST = 5'd30;

  localparam logic [2:0] USE_NONE     = 3'b000;
  localparam logic [2:0] USE_RD       = 3'b001;
  localparam logic [2:0] USE_RS1      = 3'b010;
  localparam logic [2:0] USE_RD_RS1   = 3'b011;
  localparam logic [2:0] USE_RS1_RS2  = 3'b110;
  localparam logic [2:0] USE_ALL      = 3'b111;

  typedef struct packed {
    op_class_t   cls;
    alu_op_t     alu;
    logic        word;
    logic [2:0]  use_m;
    logic [4:0]  dst;
    logic [4:0]  src1;
    logic [4:0]  src2;
    logic [3:0]  msz;
    logic        msg;
    logic [2:0]  f3;
    imm_fmt_t    fmt;
    logic        add_pc;
  } dec_t;

  function automatic alu_op_t alu_sel(input logic [2:0] f3, input logic b30,
                                      input logic has_logic, input logic is_imm);
    alu_op_t a;
    unique case (f3)
      3'd0: a = (b30 && !is_imm) ? ALU_SUB : ALU_ADD;
      3'd1: a = b30 ? ALU_NONE : ALU_SLL;
      3'd5: a = b30 ? ALU_SRA : ALU_SRL;
      3'd2, 3'd3: a = has_logic ? ALU_SLT : ALU_NONE;
      3'd4: a = has_logic ? ALU_XOR : ALU_NONE;
      3'd6: a = has_logic ? ALU_OR : ALU_NONE;
      3'd7: a = has_logic ? ALU_AND : ALU_NONE;
      default: a = ALU_NONE;
    endcase
    return a;
  endfunction

endpackage

@@ design/rvd_if.sv @@
// ----------------------------------------------------------------------------
// RV64I decoder channels
// Valid/ready channel for instruction items and for decoded record items.
// ----------------------------------------------------------------------------
interface rvd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pc;
  logic [31:0] instr;

  modport source (output valid, output pc, output instr, input ready);
  modport sink   (input valid, input pc, input instr, output ready);
endinterface

interface rvd_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         op_class;
  logic [3:0]         alu_op;
  logic               word_op;
  logic [2:0]         use_mask;
  logic [4:0]         dest_reg;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic signed [63:0] imm_value;
  logic [32:0]        pc_next;
  logic [3:0]         mem_size;
  logic               mem_signed;
  logic [2:0]         func3;

  modport source (output valid, output op_class, output alu_op, output word_op,
                  output use_mask, output dest_reg, output src1_reg, output src2_reg,
                  output imm_value, output pc_next, output mem_size, output mem_signed,
                  output func3, input ready);
  modport sink   (input valid, input op_class, input alu_op, input word_op,
                  input use_mask, input dest_reg, input src1_reg, input src2_reg,
                  input imm_value, input pc_next, input mem_size, input mem_signed,
                  input func3, output ready);
endinterface

@@ design/rv64i_instruction_decoder.sv @@
// ----------------------------------------------------------------------------
// RV64I instruction decoder
// Decodes each pc and instruction word into one record per cycle unless stalled.
//
//   Channel  Direction  Carries
//   in_ch    in         pc, instr
//   out_ch   out        op_class, alu_op, word_op, use_mask, regs, imm, pc_next,
//                       mem_size, mem_signed, func3
//
// Three register stages: field decode, immediate build and pc + 4, then the
// auipc add. One item is taken in every cycle while the pipeline is not stalled.
// A stage holds its item while the stage after it is full and stalled, so
// in_ch.ready falls only when all three stages are full and out_ch.ready is low.
// Reset (rst_n, synchronous) empties the pipeline.
// ----------------------------------------------------------------------------
module rv64i_instruction_decoder (
  input  logic clk,
  input  logic rst_n,
  rvd_in_if.sink    in_ch,
  rvd_out_if.source out_ch
);
  import rvd_pkg::*;

  logic               v1_r, v2_r, v3_r;
  logic               ld1, ld2, ld3;
  dec_t               dec;
  dec_t               dec1_r, dec2_r, dec3_r;
  logic [31:0]        pc1_r, pc2_r;
  logic [31:7]        ins1_r;
  logic [32:0]        pcn2_r, pcn3_r;
  logic [63:0]        imm2_nxt, imm2_r, imm3_nxt, imm3_r;

  assign ld3 = !v3_r || out_ch.ready;
  assign ld2 = !v2_r || ld3;
  assign ld1 = !v1_r || ld2;
  assign in_ch.ready = ld1;

  always_comb begin
    logic [31:0] w;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic        is_imm;
    logic        full;
    alu_op_t     a;
    w      = in_ch.instr;
    opc    = w[6:0];
    f3     = w[14:12];
    is_imm = (opc == OPC_OPIMM) || (opc == OPC_OPIMM32);
    full   = (opc == OPC_OP) || (opc == OPC_OPIMM);
    a      = alu_sel(f3, w[30], full, is_imm);
    dec        = '0;
    dec.cls    = CLS_UNKNOWN;
    dec.alu    = ALU_NONE;
    dec.fmt    = IMM_NONE;
    dec.f3     = f3;
    priority if (w == W_NOP) begin
      dec.cls = CLS_NOP;
    end else if (w == W_ECALL) begin
      dec.cls = CLS_ECALL;
    end else if (w == W_MRET) begin
      dec.cls = CLS_MRET;
    end else if (opc == OPC_SYSTEM) begin
      if (w == W_CSR_SRC_A || w == W_CSR_SRC_B) begin
        dec.cls   = CLS_CSR_USE;
        dec.use_m = USE_RS1;
        dec.src1  = REG_CSR_SRC;
      end else if (w == W_CSR_DST) begin
        dec.cls   = CLS_CSR_USE;
        dec.use_m = USE_RD;
        dec.dst   = REG_CSR_DST;
      end else begin
        dec.cls = CLS_CSR_NONE;
      end
    end else if (w == W_FENCE) begin
      dec.cls = CLS_FENCE;
    end else if (opc == OPC_LOAD) begin
      if (f3 != 3'd7) begin
        dec.cls   = CLS_LOAD;
        dec.use_m = USE_RD_RS1;
        dec.dst   = w[11:7];
        dec.src1  = w[19:15];
        dec.fmt   = IMM_I;
        dec.msz   = 4'd1 << f3[1:0];
        dec.msg   = !f3[2];
      end
    end else if (opc == OPC_STORE) begin
      if (!f3[2]) begin
        dec.cls   = CLS_STORE;
        dec.use_m = USE_RS1_RS2;
        dec.src1  = w[19:15];
        dec.src2  = w[24:20];
        dec.fmt   = IMM_S;
        dec.msz   = 4'd1 << f3[1:0];
        dec.msg   = 1'b1;
      end
    end else if (opc == OPC_LUI || opc == OPC_AUIPC) begin
      dec.cls    = CLS_UPPER;
      dec.use_m  = USE_RD;
      dec.dst    = w[11:7];
      dec.fmt    = IMM_U;
      dec.add_pc = (opc == OPC_AUIPC);
    end else if (opc == OPC_JAL) begin
      dec.cls   = CLS_JUMP;
      dec.alu   = ALU_ADD;
      dec.use_m = USE_RD;
      dec.dst   = w[11:7];
      dec.fmt   = IMM_J;
    end else if (opc == OPC_JALR) begin
      dec.cls   = CLS_JUMP;
      dec.alu   = ALU_ADD;
      dec.use_m = USE_RD_RS1;
      dec.dst   = w[11:7];
      dec.src1  = w[19:15];
      dec.fmt   = IMM_I;
    end else if (opc == OPC_BRANCH) begin
      dec.cls   = CLS_BRANCH;
      dec.alu   = ALU_ADD;
      dec.use_m = USE_RS1_RS2;
      dec.src1  = w[19:15];
      dec.src2  = w[24:20];
      dec.fmt   = IMM_B;
    end else if (opc == OPC_OP || opc == OPC_OP32 || opc == OPC_OPIMM
                 || opc == OPC_OPIMM32) begin
      if (a != ALU_NONE) begin
        dec.cls  = CLS_ALU;
        dec.alu  = a;
        dec.word = !full;
        dec.dst  = w[11:7];
        dec.src1 = w[19:15];
        if (is_imm) begin
          dec.use_m = USE_RD_RS1;
          dec.fmt   = IMM_I;
          if (a == ALU_SLL || a == ALU_SRL || a == ALU_SRA) begin
            dec.src2 = w[24:20];
          end
        end else begin
          dec.use_m = USE_ALL;
          dec.src2  = w[24:20];
        end
      end
    end else begin
      dec.cls = CLS_UNKNOWN;
    end
  end

  always_comb begin
    logic [31:7] i;
    i = ins1_r;
    unique case (dec1_r.fmt)
      IMM_I:   imm2_nxt = {{52{i[31]}}, i[31:20]};
      IMM_S:   imm2_nxt = {{52{i[31]}}, i[31:25], i[11:7]};
      IMM_B:   imm2_nxt = {{52{i[31]}}, i[7], i[30:25], i[11:8], 1'b0};
      IMM_U:   imm2_nxt = {{32{i[31]}}, i[31:12], 12'b0};
      IMM_J:   imm2_nxt = {{44{i[31]}}, i[19:12], i[20], i[30:21], 1'b0};
      default: imm2_nxt = '0;
    endcase
  end

  assign imm3_nxt = imm2_r + (dec2_r.add_pc ? {32'b0, pc2_r} : 64'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= in_ch.valid;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
      if (ld3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      dec1_r <= dec;
      pc1_r  <= in_ch.pc;
      ins1_r <= in_ch.instr[31:7];
    end
    if (ld2) begin
      dec2_r <= dec1_r;
      pc2_r  <= pc1_r;
      imm2_r <= imm2_nxt;
      pcn2_r <= {1'b0, pc1_r} + 33'd4;
    end
    if (ld3) begin
      dec3_r <= dec2_r;
      imm3_r <= imm3_nxt;
      pcn3_r <= pcn2_r;
    end
  end

  assign out_ch.valid      = v3_r;
  assign out_ch.op_class   = dec3_r.cls;
  assign out_ch.alu_op     = dec3_r.alu;
  assign out_ch.word_op    = dec3_r.word;
  assign out_ch.use_mask   = dec3_r.use_m;
  assign out_ch.dest_reg   = dec3_r.dst;
  assign out_ch.src1_reg   = dec3_r.src1;
  assign out_ch.src2_reg   = dec3_r.src2;
  assign out_ch.imm_value  = imm3_r;
  assign out_ch.pc_next    = pcn3_r;
  assign out_ch.mem_size   = dec3_r.msz;
  assign out_ch.mem_signed = dec3_r.msg;
  assign out_ch.func3      = dec3_r.f3;

  a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !ld2) |=> (v1_r && $stable(pc1_r) && $stable(ins1_r)))
    else $error("stage 1 item changed while stalled");

  a_mem_size: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> ((out_ch.mem_size != 4'd0) ==
              (dec3_r.cls == CLS_LOAD || dec3_r.cls == CLS_STORE)))
    else $error("memory size given outside a load or store");

  a_no_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && (dec3_r.cls == CLS_STORE || dec3_r.cls == CLS_BRANCH || dec3_r.cls == CLS_UNKNOWN))
      |-> (!out_ch.use_mask[0] && out_ch.dest_reg == 5'd0))
    else $error("destination register marked on a class without one");

endmodule
